/* src/upsh_pkg.sv */
// ----------------------------------------------------------------------------
// upsh_pkg
// Shared types and constants for the unordered pair hash set.
// ----------------------------------------------------------------------------
package upsh_pkg;

  localparam int KEY_W = 64;
  localparam int ENT_W = 32;
  localparam int CNT_OUT_W = 11;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RESULT
  } state_t;

endpackage

/* src/upsh_req_if.sv */
// ----------------------------------------------------------------------------
// upsh_req_if
// Request channel: opcode and the two entity ids of a pair.
// ----------------------------------------------------------------------------
interface upsh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] first_entity;
  logic [31:0] second_entity;

  modport source (output valid, opcode, first_entity, second_entity, input ready);
  modport sink   (input valid, opcode, first_entity, second_entity, output ready);
endinterface

/* src/upsh_rsp_if.sv */
// ----------------------------------------------------------------------------
// upsh_rsp_if
// Response channel: status and pair count of one request.
// ----------------------------------------------------------------------------
interface upsh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] pair_count;

  modport source (output valid, status, pair_count, input ready);
  modport sink   (input valid, status, pair_count, output ready);
endinterface

/* src/upsh_cfg_if.sv */
// ----------------------------------------------------------------------------
// upsh_cfg_if
// Configuration write channel for the invalid entity id.
// ----------------------------------------------------------------------------
interface upsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] invalid_entity;

  modport source (output valid, invalid_entity, input ready);
  modport sink   (input valid, invalid_entity, output ready);
endinterface

/* src/unordered_pair_hash_set.sv */
// ----------------------------------------------------------------------------
// unordered_pair_hash_set
// Open-addressed set of unordered entity id pairs, linear probing.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | word
//  cfg     | in  | valid/ready  | invalid_entity
//  req     | in  | valid/ready  | opcode, first_entity, second_entity
//  rsp     | out | valid/ready  | status, pair_count
//
//  One request at a time. Insert, remove and contains take the word, run
//  the key through the shared multiplier hash unit, read and compare each
//  probed slot in the memory, then load the response. Remove then pulls
//  each following entry of the run out, rehashes and reprobes it, and reads
//  the empty slot that ends the run. An invalid pair goes straight to the
//  response. Clear, and reset, sweep the slot memory, one slot a cycle,
//  with req not ready. cfg is always ready; the response sits in an
//  output register, so a new request is taken while rsp stalls.
// ----------------------------------------------------------------------------
module unordered_pair_hash_set #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic clk,
  input  logic rst,
  upsh_cfg_if.sink   cfg,
  upsh_req_if.sink   req,
  upsh_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int LOAD_LIMIT = TABLE_SLOTS - TABLE_SLOTS / 4;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

  upsh_pkg::state_t state, state_next;

  logic [31:0]       invalid_entity;
  logic [1:0]        op;
  upsh_pkg::key_t    cur_key;
  logic              reinsert;
  logic              clr_op;
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  scan;
  logic [CNT_W-1:0]  count;
  logic [1:0]        status;

  logic              rsp_valid;
  logic [1:0]        rsp_status;
  logic [10:0]       rsp_count;

  // Request decode.
  logic              bad_pair;
  logic              a_lt_b;
  upsh_pkg::key_t    new_key;
  logic              take;

  // Memory and hash unit.
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  upsh_pkg::slot_t   wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  upsh_pkg::slot_t   rd_data;
  logic              mix_start;
  upsh_pkg::key_t    mix_key;
  logic              mix_done;
  upsh_pkg::key_t    mix_hash;

  logic              hit;
  logic              empty;
  logic              full;

  always_comb begin
    bad_pair = req.first_entity == invalid_entity ||
               req.second_entity == invalid_entity ||
               req.first_entity == req.second_entity;
    a_lt_b   = req.first_entity < req.second_entity;
    new_key  = a_lt_b ? {req.first_entity, req.second_entity}
                      : {req.second_entity, req.first_entity};
    take     = req.valid && state == upsh_pkg::S_IDLE;
    hit      = rd_data.valid && rd_data.key == cur_key;
    empty    = !rd_data.valid;
    full     = count >= CNT_W'(LOAD_LIMIT);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      upsh_pkg::S_CLEAR: begin
        if (clr_idx == IDX_LAST) begin
          state_next = clr_op ? upsh_pkg::S_RESULT : upsh_pkg::S_IDLE;
        end
      end
      upsh_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.opcode == upsh_pkg::OP_CLEAR) begin
            state_next = upsh_pkg::S_CLEAR;
          end else if (bad_pair) begin
            state_next = upsh_pkg::S_RESULT;
          end else begin
            state_next = upsh_pkg::S_HASH;
          end
        end
      end
      upsh_pkg::S_HASH: begin
        if (mix_done) begin
          state_next = upsh_pkg::S_PROBE_RD;
        end
      end
      upsh_pkg::S_PROBE_RD: begin
        state_next = upsh_pkg::S_PROBE_CMP;
      end
      upsh_pkg::S_PROBE_CMP: begin
        if (!hit && !empty) begin
          state_next = upsh_pkg::S_PROBE_RD;
        end else if (reinsert || (op == upsh_pkg::OP_REMOVE && hit)) begin
          state_next = upsh_pkg::S_SCAN_RD;
        end else begin
          state_next = upsh_pkg::S_RESULT;
        end
      end
      upsh_pkg::S_SCAN_RD: begin
        state_next = upsh_pkg::S_SCAN_CMP;
      end
      upsh_pkg::S_SCAN_CMP: begin
        state_next = rd_data.valid ? upsh_pkg::S_HASH : upsh_pkg::S_RESULT;
      end
      upsh_pkg::S_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = upsh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = upsh_pkg::S_IDLE;
      end
    endcase
  end

  // Memory, hash unit and handshake controls.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = slot;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = slot;
    mix_start = 1'b0;
    mix_key   = cur_key;
    case (state)
      upsh_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
      end
      upsh_pkg::S_IDLE: begin
        mix_start = req.valid && req.opcode != upsh_pkg::OP_CLEAR && !bad_pair;
        mix_key   = new_key;
      end
      upsh_pkg::S_PROBE_RD: begin
        rd_en = 1'b1;
      end
      upsh_pkg::S_PROBE_CMP: begin
        if (reinsert) begin
          // Drop the moved entry into the first free slot of its chain.
          wr_en   = empty;
          wr_data = '{valid: 1'b1, key: cur_key};
        end else if (op == upsh_pkg::OP_INSERT) begin
          wr_en   = empty && !full;
          wr_data = '{valid: 1'b1, key: cur_key};
        end else if (op == upsh_pkg::OP_REMOVE) begin
          wr_en = hit;
        end
      end
      upsh_pkg::S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = scan;
      end
      upsh_pkg::S_SCAN_CMP: begin
        // Pull the next run entry out and rehash it.
        wr_en     = rd_data.valid;
        wr_addr   = scan;
        mix_start = rd_data.valid;
        mix_key   = rd_data.key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= upsh_pkg::S_CLEAR;
      clr_idx        <= '0;
      clr_op         <= 1'b0;
      count          <= '0;
      invalid_entity <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        invalid_entity <= cfg.invalid_entity;
      end
      // Load a new response word, or drop the one just taken.
      if (state == upsh_pkg::S_RESULT && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        upsh_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        upsh_pkg::S_IDLE: begin
          if (take && req.opcode == upsh_pkg::OP_CLEAR) begin
            clr_op  <= 1'b1;
            clr_idx <= '0;
            count   <= '0;
          end
        end
        upsh_pkg::S_PROBE_CMP: begin
          if (!reinsert && op == upsh_pkg::OP_INSERT && empty && !full) begin
            count <= count + 1'b1;
          end else if (!reinsert && op == upsh_pkg::OP_REMOVE && hit) begin
            count <= count - 1'b1;
          end
        end
        upsh_pkg::S_RESULT: begin
          if (!rsp_valid || rsp.ready) begin
            clr_op <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      upsh_pkg::S_IDLE: begin
        if (take) begin
          op       <= req.opcode;
          cur_key  <= new_key;
          reinsert <= 1'b0;
          status   <= (bad_pair && req.opcode != upsh_pkg::OP_CLEAR) ?
                      upsh_pkg::ST_INVALID : upsh_pkg::ST_OK;
        end
      end
      upsh_pkg::S_HASH: begin
        if (mix_done) begin
          slot <= mix_hash[IDX_W-1:0];
        end
      end
      upsh_pkg::S_PROBE_CMP: begin
        if (!hit && !empty) begin
          slot <= slot + 1'b1;
        end else if (reinsert) begin
          scan <= scan + 1'b1;
        end else begin
          scan <= slot + 1'b1;
          case (op)
            upsh_pkg::OP_INSERT: begin
              status <= hit ? upsh_pkg::ST_MISS :
                        full ? upsh_pkg::ST_FULL : upsh_pkg::ST_OK;
            end
            default: begin
              status <= hit ? upsh_pkg::ST_OK : upsh_pkg::ST_MISS;
            end
          endcase
        end
      end
      upsh_pkg::S_SCAN_CMP: begin
        if (rd_data.valid) begin
          cur_key  <= rd_data.key;
          reinsert <= 1'b1;
        end
      end
      upsh_pkg::S_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_status <= status;
          rsp_count  <= 11'(count);
        end
      end
      default: begin
      end
    endcase
  end

  upsh_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .key   (mix_key),
    .done  (mix_done),
    .hash  (mix_hash)
  );

  upsh_table #(.IDX_W(IDX_W)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg.ready      = 1'b1;
  assign req.ready      = state == upsh_pkg::S_IDLE;
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.pair_count = rsp_count;

endmodule

/* src/upsh_mix.sv */
// ----------------------------------------------------------------------------
// upsh_mix
// Iterative 64-bit mixing finalizer on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module upsh_mix (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  upsh_pkg::key_t  key,
  output logic            done,
  output upsh_pkg::key_t  hash
);

  localparam logic [3:0] STEP_IDLE = 4'd0;
  localparam logic [3:0] STEP_END1 = 4'd4;
  localparam logic [3:0] STEP_LAST = 4'd8;

  logic [3:0]  step;
  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] cst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] sum;

  // Each 64-bit product mod 2^64 is lo*lo plus the two cross terms shifted up.
  always_comb begin
    cst   = (step < STEP_END1 + 4'd1) ? upsh_pkg::MIX_C1 : upsh_pkg::MIX_C2;
    mul_a = (step == 4'd3 || step == 4'd7) ? v[63:32] : v[31:0];
    mul_b = (step == 4'd2 || step == 4'd6) ? cst[63:32] : cst[31:0];
    sum   = acc + {prod[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 4'd1;
      end else if (step == STEP_LAST) begin
        step <= STEP_IDLE;
        done <= 1'b1;
      end else if (step != STEP_IDLE) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= key ^ (key >> 30);
    end else begin
      case (step)
        4'd1, 4'd5: begin
          prod <= mul_a * mul_b;
        end
        4'd2, 4'd6: begin
          acc  <= prod;
          prod <= mul_a * mul_b;
        end
        4'd3, 4'd7: begin
          acc  <= sum;
          prod <= mul_a * mul_b;
        end
        STEP_END1: begin
          v <= sum ^ (sum >> 27);
        end
        STEP_LAST: begin
          v <= sum ^ (sum >> 31);
        end
        default: begin
        end
      endcase
    end
  end

  assign hash = v;

endmodule

/* src/upsh_table.sv */
// ----------------------------------------------------------------------------
// upsh_table
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module upsh_table #(
  parameter int IDX_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  upsh_pkg::slot_t   wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output upsh_pkg::slot_t   rd_data
);

  upsh_pkg::slot_t mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
